@@ rtl/i2c_mrt_pkg.sv @@
`timescale 1ns / 1ps

package i2c_mrt_pkg;

  typedef enum logic [1:0] {
    REQ_TICK       = 2'd0,
    REQ_BEGIN_WR   = 2'd1,
    REQ_BEGIN_RD   = 2'd2,
    REQ_NEXT_BYTE  = 2'd3
  } req_e;

  localparam logic [7:0] ACK_WAIT_RESET = 8'd250;
  localparam int unsigned BYTE_BITS     = 8;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

endpackage

@@ rtl/i2c_master_register_transfer.sv @@
// Result: each accepted word's result word is registered on the output register in the next cycle.
// Throughput: one word per cycle; a word is taken while the output register is empty
// or is being emptied in the same cycle.
// Reset: asynchronous, active low; sequencer idle, SCL and SDA released high,
// acknowledge wait limit 250, no result word pending.
`timescale 1ns / 1ps

module i2c_master_register_transfer
  import i2c_mrt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [15:0] byte_count_i,
  input  logic [7:0]  write_byte_i,
  input  logic        sda_in_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_level_o,
  output logic        sda_release_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o,
  output logic        want_byte_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        status_o
);

  typedef enum logic [3:0] {
    P_IDLE   = 4'd0,
    P_START  = 4'd1,
    P_AWS    = 4'd2,
    P_AWA    = 4'd3,
    P_RGS    = 4'd4,
    P_RGA    = 4'd5,
    P_RSTART = 4'd6,
    P_ARS    = 4'd7,
    P_ARA    = 4'd8,
    P_WANT   = 4'd9,
    P_DTS    = 4'd10,
    P_DTA    = 4'd11,
    P_READ   = 4'd12,
    P_MACK   = 4'd13,
    P_STOP   = 4'd14,
    P_STOPN  = 4'd15
  } phase_e;

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  phase_e                  phase_q, phase_d;
  logic [1:0]              sub_q, sub_d;
  logic [3:0]              bit_q, bit_d;
  logic [BYTE_BITS-1:0]    shift_q, shift_d;
  logic [COUNT_BITS-1:0]   left_q, left_d;
  logic [6:0]              addr_q, addr_d;
  logic [7:0]              reg_q, reg_d;
  logic                    rd_q, rd_d;
  logic [7:0]              wait_q, wait_d;
  logic                    scl_q, scl_d;
  logic                    sda_q, sda_d;
  logic [7:0]              limit_q;

  logic                    out_valid_q;
  logic                    rv_d;
  logic [7:0]              rb_d;
  logic                    done_d, st_d;
  logic                    in_fire;

  logic [COUNT_BITS-1:0]   left_dec;
  logic [3:0]              bit_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;
  assign left_dec    = left_q - CNT_ONE;
  assign bit_inc     = bit_q + 4'd1;

  always_comb begin
    phase_d = phase_q;
    sub_d   = sub_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    addr_d  = addr_q;
    reg_d   = reg_q;
    rd_d    = rd_q;
    wait_d  = wait_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rv_d    = 1'b0;
    rb_d    = '0;
    done_d  = 1'b0;
    st_d    = 1'b0;

    if (req_type_i == REQ_BEGIN_WR || req_type_i == REQ_BEGIN_RD) begin
      if (phase_q == P_IDLE) begin
        addr_d  = dev_addr_i;
        reg_d   = reg_addr_i;
        rd_d    = (req_type_i == REQ_BEGIN_RD);
        left_d  = byte_count_i[COUNT_BITS-1:0];
        if (req_type_i == REQ_BEGIN_RD && byte_count_i[COUNT_BITS-1:0] == '0) begin
          left_d = CNT_ONE;
        end
        phase_d = P_START;
        sub_d   = 2'd0;
        bit_d   = 4'd0;
      end
    end else if (req_type_i == REQ_NEXT_BYTE) begin
      if (phase_q == P_WANT) begin
        shift_d = write_byte_i;
        phase_d = P_DTS;
        sub_d   = 2'd0;
        bit_d   = 4'd0;
      end
    end else begin
      unique case (phase_q)
        P_START, P_RSTART: begin
          case (sub_q)
            2'd0: begin sda_d = 1'b1; sub_d = 2'd1; end
            2'd1: begin scl_d = 1'b1; sub_d = 2'd2; end
            2'd2: begin sda_d = 1'b0; sub_d = 2'd3; end
            default: begin
              scl_d   = 1'b0;
              shift_d = {addr_q, (phase_q == P_RSTART)};
              phase_d = (phase_q == P_RSTART) ? P_ARS : P_AWS;
              sub_d   = 2'd0;
              bit_d   = 4'd0;
            end
          endcase
        end
        P_AWS, P_RGS, P_ARS, P_DTS: begin
          if (sub_q == 2'd0) begin
            scl_d = 1'b0;
            sda_d = shift_q[BYTE_BITS-1];
            sub_d = 2'd1;
          end else if (sub_q == 2'd1) begin
            scl_d = 1'b1;
            sub_d = 2'd2;
          end else begin
            scl_d   = 1'b0;
            shift_d = {shift_q[BYTE_BITS-2:0], 1'b0};
            bit_d   = bit_inc;
            sub_d   = 2'd0;
            if (bit_inc >= BITS_PER_BYTE) begin
              bit_d = 4'd0;
              case (phase_q)
                P_AWS:   phase_d = P_AWA;
                P_RGS:   phase_d = P_RGA;
                P_ARS:   phase_d = P_ARA;
                default: phase_d = P_DTA;
              endcase
            end
          end
        end
        P_AWA, P_RGA, P_ARA, P_DTA: begin
          if (sub_q == 2'd0) begin
            scl_d = 1'b0;
            sda_d = 1'b1;
            sub_d = 2'd1;
          end else if (sub_q == 2'd1) begin
            scl_d  = 1'b1;
            wait_d = 8'd0;
            sub_d  = 2'd2;
          end else if (!sda_in_i) begin
            scl_d = 1'b0;
            sub_d = 2'd0;
            bit_d = 4'd0;
            case (phase_q)
              P_AWA: begin
                shift_d = reg_q;
                phase_d = P_RGS;
              end
              P_RGA: begin
                if (rd_q) begin
                  phase_d = P_RSTART;
                end else begin
                  phase_d = (left_q == '0) ? P_STOP : P_WANT;
                end
              end
              P_ARA: begin
                shift_d = '0;
                phase_d = P_READ;
              end
              default: begin
                left_d  = left_dec;
                phase_d = (left_dec == '0) ? P_STOP : P_WANT;
              end
            endcase
          end else if (wait_q >= limit_q) begin
            phase_d = P_STOPN;
            sub_d   = 2'd0;
            bit_d   = 4'd0;
          end else begin
            wait_d = wait_q + 8'd1;
          end
        end
        P_READ: begin
          if (sub_q == 2'd0) begin
            scl_d = 1'b0;
            sda_d = 1'b1;
            sub_d = 2'd1;
          end else if (sub_q == 2'd1) begin
            scl_d = 1'b1;
            sub_d = 2'd2;
          end else begin
            shift_d = {shift_q[BYTE_BITS-2:0], sda_in_i};
            bit_d   = bit_inc;
            sub_d   = 2'd0;
            if (bit_inc >= BITS_PER_BYTE) begin
              rv_d    = 1'b1;
              rb_d    = {shift_q[BYTE_BITS-2:0], sda_in_i};
              phase_d = P_MACK;
              bit_d   = 4'd0;
            end
          end
        end
        P_MACK: begin
          if (sub_q == 2'd0) begin
            scl_d = 1'b0;
            sda_d = (left_q > CNT_ONE) ? 1'b0 : 1'b1;
            sub_d = 2'd1;
          end else if (sub_q == 2'd1) begin
            scl_d = 1'b1;
            sub_d = 2'd2;
          end else begin
            scl_d   = 1'b0;
            sda_d   = 1'b1;
            left_d  = left_dec;
            shift_d = '0;
            phase_d = (left_dec == '0) ? P_STOP : P_READ;
            sub_d   = 2'd0;
            bit_d   = 4'd0;
          end
        end
        P_STOP, P_STOPN: begin
          if (sub_q == 2'd0) begin
            scl_d = 1'b0;
            sda_d = 1'b0;
            sub_d = 2'd1;
          end else if (sub_q == 2'd1) begin
            scl_d = 1'b1;
            sub_d = 2'd2;
          end else begin
            sda_d   = 1'b1;
            done_d  = 1'b1;
            st_d    = (phase_q == P_STOPN);
            phase_d = P_IDLE;
            sub_d   = 2'd0;
            bit_d   = 4'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= ACK_WAIT_RESET;
      phase_q       <= P_IDLE;
      sub_q         <= 2'd0;
      bit_q         <= 4'd0;
      shift_q       <= '0;
      left_q        <= '0;
      addr_q        <= '0;
      reg_q         <= '0;
      rd_q          <= 1'b0;
      wait_q        <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      out_valid_q   <= 1'b0;
      scl_level_o   <= 1'b1;
      sda_release_o <= 1'b1;
      read_byte_o   <= '0;
      read_valid_o  <= 1'b0;
      want_byte_o   <= 1'b0;
      busy_res_o    <= 1'b0;
      done_res_o    <= 1'b0;
      status_o      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q       <= phase_d;
        sub_q         <= sub_d;
        bit_q         <= bit_d;
        shift_q       <= shift_d;
        left_q        <= left_d;
        addr_q        <= addr_d;
        reg_q         <= reg_d;
        rd_q          <= rd_d;
        wait_q        <= wait_d;
        scl_q         <= scl_d;
        sda_q         <= sda_d;
        scl_level_o   <= scl_d;
        sda_release_o <= sda_d;
        read_byte_o   <= rb_d;
        read_valid_o  <= rv_d;
        want_byte_o   <= (phase_d == P_WANT);
        busy_res_o    <= (phase_d != P_IDLE);
        done_res_o    <= done_d;
        status_o      <= st_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ dv/tb_i2c_master_register_transfer.sv @@
`timescale 1ns / 1ps

module tb_i2c_master_register_transfer;
  import i2c_mrt_pkg::*;

  localparam int unsigned CNT_BITS    = 16;
  localparam logic [15:0] CNT_MASK    = 16'((33'd1 << CNT_BITS) - 33'd1);
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_WORDS = 40;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START, PH_ADDR_W_SEND, PH_ADDR_W_ACK, PH_REG_SEND, PH_REG_ACK,
    PH_RESTART, PH_ADDR_R_SEND, PH_ADDR_R_ACK, PH_WANT, PH_DATA_SEND, PH_DATA_ACK,
    PH_READ, PH_MASTER_ACK, PH_STOP, PH_STOP_NACK
  } phase_e;

  typedef enum logic [1:0] {ACK_WAIT, ACK_SEEN, ACK_TIMEOUT} ack_e;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_THREE_OF_FOUR, RX_LONG_STALL} stall_e;

  typedef struct packed {
    req_e        req;
    logic [6:0]  dev;
    logic [7:0]  rgad;
    logic [15:0] count;
    logic [7:0]  wbyte;
    logic        sda;
  } bus_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_rel;
    logic [7:0] rbyte;
    logic       rvalid;
    logic       want;
    logic       busy;
    logic       done;
    logic       status;
  } line_word_t;

  class transfer_scoreboard;
    phase_e      phase;
    logic [1:0]  sub_step;
    logic [3:0]  bit_idx;
    logic [7:0]  shifter;
    logic [15:0] left;
    logic [6:0]  addr;
    logic [7:0]  regno;
    logic        rd;
    logic [7:0]  wait_cnt;
    logic [7:0]  wait_limit;
    logic        scl;
    logic        sda;
    line_word_t  pending[$];
    int unsigned errors;

    function new();
      phase      = PH_IDLE;
      sub_step   = '0;
      bit_idx    = '0;
      shifter    = '0;
      left       = '0;
      addr       = '0;
      regno      = '0;
      rd         = 1'b0;
      wait_cnt   = '0;
      wait_limit = ACK_WAIT_RESET;
      scl        = 1'b1;
      sda        = 1'b1;
      errors     = 0;
    endfunction

    function void set_limit(logic [7:0] v);
      wait_limit = v;
    endfunction

    function void enter(phase_e p);
      phase    = p;
      sub_step = '0;
      bit_idx  = '0;
    endfunction

    function logic start_tick();
      case (sub_step)
        2'd0: begin
          sda = 1'b1;
          sub_step = 2'd1;
          return 1'b0;
        end
        2'd1: begin
          scl = 1'b1;
          sub_step = 2'd2;
          return 1'b0;
        end
        2'd2: begin
          sda = 1'b0;
          sub_step = 2'd3;
          return 1'b0;
        end
        default: begin
          scl = 1'b0;
          return 1'b1;
        end
      endcase
    endfunction

    function logic send_tick();
      if (sub_step == 2'd0) begin
        scl = 1'b0;
        sda = shifter[7];
        sub_step = 2'd1;
      end else if (sub_step == 2'd1) begin
        scl = 1'b1;
        sub_step = 2'd2;
      end else begin
        scl = 1'b0;
        shifter = {shifter[6:0], 1'b0};
        bit_idx = bit_idx + 4'd1;
        sub_step = 2'd0;
        return bit_idx >= BITS_PER_BYTE;
      end
      return 1'b0;
    endfunction

    function ack_e ack_tick(logic s);
      if (sub_step == 2'd0) begin
        scl = 1'b0;
        sda = 1'b1;
        sub_step = 2'd1;
        return ACK_WAIT;
      end
      if (sub_step == 2'd1) begin
        scl = 1'b1;
        wait_cnt = '0;
        sub_step = 2'd2;
        return ACK_WAIT;
      end
      if (!s) begin
        scl = 1'b0;
        return ACK_SEEN;
      end
      if (wait_cnt >= wait_limit) return ACK_TIMEOUT;
      wait_cnt = wait_cnt + 8'd1;
      return ACK_WAIT;
    endfunction

    function void note_word(bus_word_t w);
      line_word_t exp;
      ack_e       a;
      logic       fin;
      exp = '0;
      case (w.req)
        REQ_BEGIN_WR, REQ_BEGIN_RD: begin
          if (phase == PH_IDLE) begin
            addr  = w.dev;
            regno = w.rgad;
            rd    = (w.req == REQ_BEGIN_RD);
            left  = w.count & CNT_MASK;
            if (rd && left == 16'd0) left = 16'd1;
            enter(PH_START);
          end
        end
        REQ_NEXT_BYTE: begin
          if (phase == PH_WANT) begin
            shifter = w.wbyte;
            enter(PH_DATA_SEND);
          end
        end
        REQ_TICK: begin
          case (phase)
            PH_START, PH_RESTART: begin
              if (start_tick()) begin
                fin = (phase == PH_RESTART);
                shifter = {addr, fin};
                if (fin) enter(PH_ADDR_R_SEND);
                else enter(PH_ADDR_W_SEND);
              end
            end
            PH_ADDR_W_SEND, PH_REG_SEND, PH_ADDR_R_SEND, PH_DATA_SEND: begin
              if (send_tick()) enter(phase_e'(phase + 5'd1));
            end
            PH_ADDR_W_ACK, PH_REG_ACK, PH_ADDR_R_ACK, PH_DATA_ACK: begin
              a = ack_tick(w.sda);
              if (a == ACK_TIMEOUT) begin
                enter(PH_STOP_NACK);
              end else if (a == ACK_SEEN) begin
                case (phase)
                  PH_ADDR_W_ACK: begin
                    shifter = regno;
                    enter(PH_REG_SEND);
                  end
                  PH_REG_ACK: begin
                    if (rd) enter(PH_RESTART);
                    else if (left == 16'd0) enter(PH_STOP);
                    else enter(PH_WANT);
                  end
                  PH_ADDR_R_ACK: begin
                    shifter = '0;
                    enter(PH_READ);
                  end
                  default: begin
                    left = (left - 16'd1) & CNT_MASK;
                    if (left == 16'd0) enter(PH_STOP);
                    else enter(PH_WANT);
                  end
                endcase
              end
            end
            PH_READ: begin
              if (sub_step == 2'd0) begin
                scl = 1'b0;
                sda = 1'b1;
                sub_step = 2'd1;
              end else if (sub_step == 2'd1) begin
                scl = 1'b1;
                sub_step = 2'd2;
              end else begin
                shifter = {shifter[6:0], w.sda};
                bit_idx = bit_idx + 4'd1;
                sub_step = 2'd0;
                if (bit_idx >= BITS_PER_BYTE) begin
                  exp.rvalid = 1'b1;
                  exp.rbyte  = shifter;
                  enter(PH_MASTER_ACK);
                end
              end
            end
            PH_MASTER_ACK: begin
              if (sub_step == 2'd0) begin
                scl = 1'b0;
                sda = (left > 16'd1) ? 1'b0 : 1'b1;
                sub_step = 2'd1;
              end else if (sub_step == 2'd1) begin
                scl = 1'b1;
                sub_step = 2'd2;
              end else begin
                scl = 1'b0;
                sda = 1'b1;
                left = (left - 16'd1) & CNT_MASK;
                shifter = '0;
                if (left == 16'd0) enter(PH_STOP);
                else enter(PH_READ);
              end
            end
            PH_STOP, PH_STOP_NACK: begin
              if (sub_step == 2'd0) begin
                scl = 1'b0;
                sda = 1'b0;
                sub_step = 2'd1;
              end else if (sub_step == 2'd1) begin
                scl = 1'b1;
                sub_step = 2'd2;
              end else begin
                sda = 1'b1;
                exp.done   = 1'b1;
                exp.status = (phase == PH_STOP_NACK);
                enter(PH_IDLE);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      exp.scl     = scl;
      exp.sda_rel = sda;
      exp.want    = (phase == PH_WANT);
      exp.busy    = (phase != PH_IDLE);
      pending.push_back(exp);
    endfunction

    function string show(line_word_t v);
      return $sformatf("scl %b sda %b byte %h rvalid %b want %b busy %b done %b status %b",
                       v.scl, v.sda_rel, v.rbyte, v.rvalid, v.want, v.busy, v.done, v.status);
    endfunction

    function void check_word(line_word_t got);
      line_word_t exp;
      logic       bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      exp = pending.pop_front();
      bad = (got.scl !== exp.scl) || (got.sda_rel !== exp.sda_rel) ||
            (got.rbyte !== exp.rbyte) || (got.rvalid !== exp.rvalid) ||
            (got.want !== exp.want) || (got.busy !== exp.busy) ||
            (got.done !== exp.done) || (got.status !== exp.status);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t", $time);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_e        req_type = REQ_TICK;
  logic [6:0]  dev_addr = '0;
  logic [7:0]  reg_addr = '0;
  logic [15:0] byte_count = '0;
  logic [7:0]  write_byte = '0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_level;
  logic        sda_release;
  logic [7:0]  read_byte;
  logic        read_valid;
  logic        want_byte;
  logic        busy_res;
  logic        done_res;
  logic        status;

  transfer_scoreboard sb = new();
  int unsigned cyc = 0;
  stall_e      rx_mode = RX_FREE;
  int unsigned burst_left = 0;
  bit          holding = 1'b0;
  int unsigned sent = 0;

  i2c_master_register_transfer #(
    .COUNT_BITS(CNT_BITS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .dev_addr_i   (dev_addr),
    .reg_addr_i   (reg_addr),
    .byte_count_i (byte_count),
    .write_byte_i (write_byte),
    .sda_in_i     (sda_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .scl_level_o  (scl_level),
    .sda_release_o(sda_release),
    .read_byte_o  (read_byte),
    .read_valid_o (read_valid),
    .want_byte_o  (want_byte),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .status_o     (status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cyc % 200 == 0) rx_mode <= stall_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:          out_ready <= 1'b1;
      RX_RANDOM:        out_ready <= 1'($urandom_range(0, 1));
      RX_THREE_OF_FOUR: out_ready <= (cyc % 4 != 3);
      default:          out_ready <= (cyc % 16 < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word({scl_level, sda_release, read_byte, read_valid,
                     want_byte, busy_res, done_res, status});
  end

  function automatic bus_word_t random_word();
    bus_word_t w;
    w.req   = req_e'($urandom_range(0, 3));
    w.dev   = 7'($urandom);
    w.rgad  = 8'($urandom);
    w.count = 16'($urandom);
    w.wbyte = 8'($urandom);
    w.sda   = 1'($urandom);
    return w;
  endfunction

  task automatic send_word(input bus_word_t w);
    in_valid   <= 1'b1;
    req_type   <= w.req;
    dev_addr   <= w.dev;
    reg_addr   <= w.rgad;
    byte_count <= w.count;
    write_byte <= w.wbyte;
    sda_in     <= w.sda;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      holding = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 12);
    end else begin
      holding = 1'b1;
    end
  endtask

  task automatic drain();
    if (holding) begin
      in_valid <= 1'b0;
      holding = 1'b0;
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_transfer(input logic rd, input logic [6:0] dev, input logic [7:0] rg,
                              input logic [15:0] count, input int nack_at, input bit noisy);
    bus_word_t w;
    int        ack_no;
    bit        hold_high;
    ack_no = 0;
    hold_high = 1'b0;
    w = random_word();
    w.req   = rd ? REQ_BEGIN_RD : REQ_BEGIN_WR;
    w.dev   = dev;
    w.rgad  = rg;
    w.count = count;
    send_word(w);
    while (sb.phase != PH_IDLE) begin
      w = random_word();
      w.req = REQ_TICK;
      if (noisy && $urandom_range(0, 24) == 0) begin
        if (sb.phase == PH_WANT || $urandom_range(0, 2) != 0)
          w.req = $urandom_range(0, 1) ? REQ_BEGIN_RD : REQ_BEGIN_WR;
        else
          w.req = REQ_NEXT_BYTE;
      end else if (sb.phase == PH_WANT) begin
        if ($urandom_range(0, 9) < 8) w.req = REQ_NEXT_BYTE;
      end else if (sb.phase inside {PH_ADDR_W_ACK, PH_REG_ACK, PH_ADDR_R_ACK, PH_DATA_ACK}) begin
        if (sb.sub_step == 2'd0) begin
          ack_no++;
          hold_high = (ack_no == nack_at) || ($urandom_range(0, 40) == 0);
        end
        w.sda = hold_high || (sb.wait_limit != 0 && $urandom_range(0, 5) == 0);
      end
      send_word(w);
    end
  endtask

  task automatic random_traffic(input int unsigned words);
    int unsigned stop_at;
    bus_word_t   w;
    logic        rd;
    logic [15:0] count;
    int          nack_at;
    int unsigned pick;
    stop_at = sent + words;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        w = random_word();
        if (w.req inside {REQ_BEGIN_WR, REQ_BEGIN_RD}) w.req = REQ_TICK;
        send_word(w);
      end else begin
        rd = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        nack_at = 0;
        if (pick < 6) begin
          count = 16'($urandom_range(0, 2));
        end else if (pick < 9) begin
          count = 16'($urandom_range(3, 5));
        end else begin
          // long counts: abort before any data moves
          count = 16'($urandom);
          nack_at = $urandom_range(1, rd ? 3 : 2);
        end
        if (nack_at == 0 && $urandom_range(0, 9) == 0) nack_at = $urandom_range(1, 4);
        run_transfer(rd, 7'($urandom), 8'($urandom), count, nack_at, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word('{REQ_TICK, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1});
    send_word('{REQ_NEXT_BYTE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0});
    run_transfer(1'b0, 7'h00, 8'h00, 16'd0, 0, 1'b0);
    run_transfer(1'b0, 7'h7F, 8'hFF, 16'd2, 0, 1'b1);
    run_transfer(1'b1, 7'h55, 8'hAA, 16'd0, 0, 1'b0);
    drain();
    write_limit(8'd1);
    run_transfer(1'b0, 7'h11, 8'h22, 16'hFFFF, 1, 1'b0);
    run_transfer(1'b1, 7'h33, 8'h44, 16'h8000, 2, 1'b0);
    run_transfer(1'b0, 7'h66, 8'h77, 16'd1, 3, 1'b0);
    drain();

    write_limit(8'd0);
    random_traffic(PHASE_WORDS);
    drain();
    write_limit(8'd255);
    random_traffic(PHASE_WORDS);
    // hold off until the pipeline is empty, then carry on
    drain();
    write_limit(8'($urandom_range(2, 40)));
    random_traffic(PHASE_WORDS);
    drain();
    write_limit(ACK_WAIT_RESET);
    random_traffic(PHASE_WORDS);
    drain();

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/i2c_mrt_pkg.sv
rtl/i2c_master_register_transfer.sv
dv/tb_i2c_master_register_transfer.sv
